FILE: rtl/athx_pkg.sv
package athx_pkg;

    localparam int SINE_LENGTH = 512;
    localparam int PHASE_W     = $clog2(SINE_LENGTH);
    localparam int BIT_RATE    = 1200;
    localparam int STUFF_RUN   = 5;

    localparam int MS_W   = 12;
    localparam int INC_W  = 9;
    localparam int SPB_W  = 8;
    localparam int ONES_W = 3;

    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] RESET_BYTE = 8'h7F;
    localparam logic [7:0] ESC_BYTE   = 8'h1B;

    localparam int FLAGS_W               = 10;
    localparam logic [FLAGS_W-1:0] FLAGS_MAX = '1;

    // Flag count = (ms * BIT_RATE + 4000) / 8000, done as a shift by 6 and a
    // multiplication by the reciprocal of 125.
    localparam int MS_MAX     = (1 << MS_W) - 1;
    localparam int HALF_DIV   = 4000;
    localparam int DIV_SHIFT  = 6;
    localparam int DIV_ODD    = 125;
    localparam int PROD_W     = $clog2(MS_MAX * BIT_RATE + HALF_DIV + 1);
    localparam int Y_W        = PROD_W - DIV_SHIFT;
    localparam int RECIP_SH   = 27;
    localparam int RECIP      = ((1 << RECIP_SH) + DIV_ODD - 1) / DIV_ODD;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int MUL_W      = Y_W + RECIP_W;
    localparam int Q_W        = MUL_W - RECIP_SH;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_FLUSH = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_MS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_MS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_INCREMENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_INCREMENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BIT = 3'd4;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_FLUSH,
        OP_TICK,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic               push_accepted;
        logic               transmitting;
        logic               tone_is_space;
        logic [PHASE_W-1:0] phase;
    } result_t;

    typedef struct packed {
        logic sending;
        logic fifo_empty;
        logic fifo_full;
    } back_status_t;

endpackage

FILE: rtl/afsk_hdlc_tone_transmitter.sv
// Channel  Direction  Beat contents
// s_axis   in         tuser: kind; tdata: data_byte
// m_axis   out        tdata: phase, tone_is_space, transmitting, push_accepted
// cfg      in         write enable, register index, write data
//
// One beat per clock cycle is sustained in both directions while the output is not stalled;
// each input beat gives one output beat, passing the front register, queue and output register.
// Reset clears all control state and loads the register defaults; FIFO contents stay
// undefined until written. Input ready drops only when the front register and the
// two-entry queue are both full; the back end waits only on an output stall.
module afsk_hdlc_tone_transmitter #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]                        s_axis_tuser,   // [1:0] kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [8:0] phase, [9] tone_is_space, [10] transmitting, [11] push_accepted
    output logic [15:0]                       m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [athx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [athx_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import athx_pkg::*;

    logic         f_valid;
    logic         q_ready;
    item_t        f_item;
    logic         q_valid;
    logic         q_pop;
    item_t        q_item;
    result_t      result;
    back_status_t status;

    athx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (f_valid),
        .out_ready (q_ready),
        .out_item  (f_item)
    );

    athx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (q_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    athx_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result),
        .status     (status)
    );

    assign m_axis_tdata = {(16 - $bits(result_t))'(0), result};

`ifndef SYNTH
    a_push_implies_sending: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[10])
        else $error("accepted push reported while not transmitting");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_item.op == OP_FLUSH |=> status.fifo_empty)
        else $error("FIFO not empty after flush");

    a_full_refuses: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_item.op == OP_PUSH && status.fifo_full |=> !m_axis_tdata[11])
        else $error("push into full FIFO reported as accepted");
`endif

endmodule

FILE: rtl/athx_front.sv
module athx_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_kind,
    input  logic [7:0]           in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output athx_pkg::item_t      out_item
);
    import athx_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next.data = in_data;
        case (in_kind)
            KIND_PUSH:  item_next.op = OP_PUSH;
            KIND_FLUSH: item_next.op = OP_FLUSH;
            KIND_TICK:  item_next.op = OP_TICK;
            default:    item_next.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: rtl/athx_queue.sv
module athx_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  athx_pkg::item_t      in_item,
    output logic                 out_valid,
    input  logic                 out_pop,
    output athx_pkg::item_t      out_item
);
    import athx_pkg::*;

    localparam int DEPTH = 2;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [IDX_W-1:0] wr_idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_idx_reg];
    assign push      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_idx_reg <= wr_idx_reg + IDX_W'(1);
            end
            if (out_pop)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            if (push && !out_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (out_pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_idx_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/athx_back.sv
module athx_back #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [athx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [athx_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                q_valid,
    input  athx_pkg::item_t                     q_item,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output athx_pkg::result_t                   out_result,
    output athx_pkg::back_status_t              status
);
    import athx_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [FLAGS_W-1:0] prod_to_flags(input logic [PROD_W-1:0] prod);
        logic [MUL_W-1:0] mul;
        logic [Q_W-1:0]   q;
        mul = MUL_W'(prod[PROD_W-1:DIV_SHIFT]) * MUL_W'(RECIP);
        q   = mul[MUL_W-1:RECIP_SH];
        prod_to_flags = (q > Q_W'(FLAGS_MAX)) ? FLAGS_MAX : q[FLAGS_W-1:0];
    endfunction

    logic [MS_W-1:0]    preamble_ms_reg;
    logic [MS_W-1:0]    tail_ms_reg;
    logic [INC_W-1:0]   mark_inc_reg;
    logic [INC_W-1:0]   space_inc_reg;
    logic [SPB_W-1:0]   spb_reg;
    logic [PROD_W-1:0]  pre_prod_reg;
    logic [PROD_W-1:0]  tail_prod_reg;
    logic [FLAGS_W-1:0] pre_flags;
    logic [FLAGS_W-1:0] tail_flags;

    logic [7:0]         fifo_mem [FIFO_DEPTH];
    logic [7:0]         head0_reg;
    logic [7:0]         head1_reg;
    logic [PW-1:0]      rp_reg, rp_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [PW-1:0]      rp1_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               wr_en;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               tone_reg, tone_next;
    logic [SPB_W-1:0]   ticks_reg, ticks_next;
    logic [7:0]         mask_reg, mask_next;
    logic [7:0]         shift_reg, shift_next;
    logic [ONES_W-1:0]  ones_reg, ones_next;
    logic               se_reg, se_next;
    logic               sending_reg, sending_next;
    logic [FLAGS_W-1:0] preamble_reg, preamble_next;
    logic [FLAGS_W-1:0] tail_reg, tail_next;
    logic               accepted;

    logic               out_valid_reg;
    result_t            result_reg;
    logic               fire;
    logic               fifo_full;

    assign fire       = q_valid && (!out_valid_reg || out_ready);
    assign q_pop      = fire;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;
    assign fifo_full  = (count_reg == CW'(FIFO_DEPTH));
    assign pre_flags  = prod_to_flags(pre_prod_reg);
    assign tail_flags = prod_to_flags(tail_prod_reg);
    assign rp1_next   = ptr_inc(rp_next);

    assign status.sending    = sending_reg;
    assign status.fifo_empty = (count_reg == '0);
    assign status.fifo_full  = fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_ms_reg <= MS_W'(350);
            tail_ms_reg     <= MS_W'(50);
            mark_inc_reg    <= INC_W'(64);
            space_inc_reg   <= INC_W'(117);
            spb_reg         <= SPB_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PREAMBLE_MS:     preamble_ms_reg <= cfg_data[MS_W-1:0];
                CFG_TAIL_MS:         tail_ms_reg     <= cfg_data[MS_W-1:0];
                CFG_MARK_INCREMENT:  mark_inc_reg    <= cfg_data[INC_W-1:0];
                CFG_SPACE_INCREMENT: space_inc_reg   <= cfg_data[INC_W-1:0];
                CFG_SAMPLES_PER_BIT: spb_reg         <= cfg_data[SPB_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pre_prod_reg  <= PROD_W'(32'(preamble_ms_reg) * 32'(BIT_RATE) + 32'(HALF_DIV));
        tail_prod_reg <= PROD_W'(32'(tail_ms_reg) * 32'(BIT_RATE) + 32'(HALF_DIV));
    end

    always_comb
    begin
        logic               stop;
        logic               pop1;
        logic               pop2;
        logic [7:0]         sb;
        logic [7:0]         mask;
        logic [ONES_W-1:0]  ones;
        logic               se;
        logic               tone;
        logic [SPB_W-1:0]   ticks;
        logic [INC_W-1:0]   inc;
        logic [PHASE_W:0]   phase_sum;

        stop = 1'b0;
        pop1 = 1'b0;
        pop2 = 1'b0;
        sb    = shift_reg;
        mask  = mask_reg;
        ones  = ones_reg;
        se    = se_reg;
        tone  = tone_reg;
        ticks = ticks_reg;
        inc   = mark_inc_reg;
        phase_sum = '0;

        rp_next       = rp_reg;
        wp_next       = wp_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        accepted      = 1'b0;
        phase_next    = phase_reg;
        tone_next     = tone_reg;
        ticks_next    = ticks_reg;
        mask_next     = mask_reg;
        shift_next    = shift_reg;
        ones_next     = ones_reg;
        se_next       = se_reg;
        sending_next  = sending_reg;
        preamble_next = preamble_reg;
        tail_next     = tail_reg;

        if (fire)
        begin
            case (q_item.op)
                OP_PUSH:
                begin
                    if (!sending_reg)
                    begin
                        tone_next     = 1'b0;
                        phase_next    = '0;
                        ones_next     = '0;
                        sending_next  = 1'b1;
                        preamble_next = pre_flags;
                    end
                    tail_next = tail_flags;
                    if (!fifo_full)
                    begin
                        wr_en      = 1'b1;
                        wp_next    = ptr_inc(wp_reg);
                        count_next = count_reg + CW'(1);
                        accepted   = 1'b1;
                    end
                end
                OP_FLUSH:
                begin
                    rp_next    = '0;
                    wp_next    = '0;
                    count_next = '0;
                end
                OP_TICK:
                begin
                    if (sending_reg)
                    begin
                        if (ticks_reg == '0)
                        begin
                            if (mask == '0)
                            begin
                                if (count_reg == '0 && tail_reg == '0)
                                begin
                                    stop = 1'b1;
                                end
                                else
                                begin
                                    if (!se)
                                    begin
                                        ones = '0;
                                    end
                                    se = 1'b1;
                                    if (preamble_reg == '0)
                                    begin
                                        if (count_reg == '0)
                                        begin
                                            tail_next = tail_reg - FLAGS_W'(1);
                                            sb = FLAG_BYTE;
                                        end
                                        else
                                        begin
                                            sb   = head0_reg;
                                            pop1 = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        preamble_next = preamble_reg - FLAGS_W'(1);
                                        sb = FLAG_BYTE;
                                    end
                                    if (sb == ESC_BYTE)
                                    begin
                                        // An escape is a FIFO byte; stop if none follows it.
                                        if (count_reg == CW'(1))
                                        begin
                                            stop = 1'b1;
                                        end
                                        else
                                        begin
                                            sb   = head1_reg;
                                            pop2 = 1'b1;
                                        end
                                    end
                                    else if (sb == FLAG_BYTE || sb == RESET_BYTE)
                                    begin
                                        se = 1'b0;
                                    end
                                    if (!stop)
                                    begin
                                        mask = 8'h01;
                                    end
                                end
                            end
                            if (!stop)
                            begin
                                if (se && ones >= ONES_W'(STUFF_RUN))
                                begin
                                    ones = '0;
                                    tone = !tone;
                                end
                                else
                                begin
                                    if ((sb & mask) != 8'h00)
                                    begin
                                        if (ones != '1)
                                        begin
                                            ones = ones + ONES_W'(1);
                                        end
                                    end
                                    else
                                    begin
                                        ones = '0;
                                        tone = !tone;
                                    end
                                    mask = {mask[6:0], 1'b0};
                                end
                                ticks = spb_reg;
                            end
                        end
                        if (stop)
                        begin
                            sending_next = 1'b0;
                        end
                        else
                        begin
                            inc        = tone ? space_inc_reg : mark_inc_reg;
                            phase_sum  = {1'b0, phase_reg} + {1'b0, inc};
                            phase_next = phase_sum[PHASE_W-1:0];
                            ticks_next = ticks - SPB_W'(1);
                        end
                        shift_next = sb;
                        mask_next  = mask;
                        ones_next  = ones;
                        se_next    = se;
                        tone_next  = tone;
                        if (pop2)
                        begin
                            rp_next    = ptr_inc(ptr_inc(rp_reg));
                            count_next = count_reg - CW'(2);
                        end
                        else if (pop1)
                        begin
                            rp_next    = ptr_inc(rp_reg);
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            phase_reg     <= '0;
            tone_reg      <= 1'b0;
            ticks_reg     <= '0;
            mask_reg      <= '0;
            shift_reg     <= '0;
            ones_reg      <= '0;
            se_reg        <= 1'b0;
            sending_reg   <= 1'b0;
            preamble_reg  <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            tone_reg     <= tone_next;
            ticks_reg    <= ticks_next;
            mask_reg     <= mask_next;
            shift_reg    <= shift_next;
            ones_reg     <= ones_next;
            se_reg       <= se_next;
            sending_reg  <= sending_next;
            preamble_reg <= preamble_next;
            tail_reg     <= tail_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The two head registers always hold the entries at the read pointer and the one after it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_mem[wp_reg] <= q_item.data;
        end
        head0_reg <= (wr_en && wp_reg == rp_next) ? q_item.data : fifo_mem[rp_next];
        head1_reg <= (wr_en && wp_reg == rp1_next) ? q_item.data : fifo_mem[rp1_next];
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg.phase         <= phase_next;
            result_reg.tone_is_space <= tone_next;
            result_reg.transmitting  <= sending_next;
            result_reg.push_accepted <= accepted;
        end
    end

endmodule
